[hw/rtl/modexp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, controller states and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of the base operand, fixed by the interface.
  localparam int unsigned BaseW = 63;

  // Modulus after reset.
  localparam logic [31:0] ModReset = 32'd998244353;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_BASE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_RED_ACC,
    ST_MUL_SQ,
    ST_RED_SQ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;       // capture a new item
    logic mul;        // register a product and arm the reducer
    logic mul_sq;     // product is square * square, else accumulator * square
    logic red_step;   // one restoring-division step of the reducer
    logic wr_acc;     // accumulator takes the reduced value
    logic wr_sq;      // square takes the reduced value
    logic shift_exp;  // drop the exponent bit just handled
  } cmd_t;

  typedef struct packed {
    logic red_last;   // the reducer is on its final step
    logic exp_zero;   // no exponent bits left
    logic exp_lsb;    // current exponent bit
    logic mod_small;  // modulus below two
  } status_t;

endpackage

[hw/rtl/modexp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus, accumulator, running square and exponent, one shared
// multiplier and a bit-serial reducer that takes a wide value modulo the
// modulus one bit per cycle.
// ----------------------------------------------------------------------------
module modexp_datapath import modexp_pkg::*; #(
  parameter int unsigned EXP_WIDTH = 63,
  parameter int unsigned MOD_WIDTH = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 cfg_we_i,
  input  logic [MOD_WIDTH-1:0] cfg_modulus_i,
  input  logic [BaseW-1:0]     base_value_i,
  input  logic [EXP_WIDTH-1:0] exponent_i,
  output logic [MOD_WIDTH-1:0] acc_o
);

  localparam int unsigned ProdW = 2 * MOD_WIDTH;
  localparam int unsigned RedW  = (ProdW > BaseW) ? ProdW : BaseW;
  localparam int unsigned CntW  = $clog2(RedW + 1);

  logic [MOD_WIDTH-1:0] mod_q;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [MOD_WIDTH-1:0] sq_q, sq_d;
  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic [RedW-1:0]      num_q, num_d;
  logic [MOD_WIDTH-1:0] rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic [MOD_WIDTH-1:0] mul_b;
  logic [ProdW-1:0]     prod;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   trial_sub;
  logic                 trial_ge;
  logic [MOD_WIDTH-1:0] rem_next;

  assign mul_b = cmd_i.mul_sq ? sq_q : acc_q;
  assign prod  = ProdW'(sq_q) * ProdW'(mul_b);

  // Restoring division step: shift in the next dividend bit and subtract
  // the modulus when the partial remainder reaches it.
  assign trial     = {rem_q, num_q[RedW-1]};
  assign trial_sub = trial - {1'b0, mod_q};
  assign trial_ge  = (trial >= {1'b0, mod_q});
  assign rem_next  = trial_ge ? trial_sub[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      num_d = RedW'(base_value_i);
      rem_d = '0;
      cnt_d = CntW'(RedW);
      exp_d = exponent_i;
      acc_d = status_o.mod_small ? '0 : MOD_WIDTH'(1);
      sq_d  = '0;
    end
    if (cmd_i.mul) begin
      num_d = RedW'(prod);
      rem_d = '0;
      cnt_d = CntW'(RedW);
    end
    if (cmd_i.red_step) begin
      num_d = num_q << 1;
      rem_d = rem_next;
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.wr_acc) begin
      acc_d = rem_next;
    end
    if (cmd_i.wr_sq) begin
      sq_d = rem_next;
    end
    if (cmd_i.shift_exp) begin
      exp_d = exp_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_WIDTH'(ModReset);
      acc_q <= '0;
      sq_q  <= '0;
      exp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_modulus_i;
      end
      acc_q <= acc_d;
      sq_q  <= sq_d;
      exp_q <= exp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign status_o.red_last  = (cnt_q == CntW'(1));
  assign status_o.exp_zero  = (exp_q == '0);
  assign status_o.exp_lsb   = exp_q[0];
  assign status_o.mod_small = (mod_q < MOD_WIDTH'(2));

  assign acc_o = acc_q;

endmodule

[hw/rtl/modexp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, then per exponent bit an optional multiply into
// the accumulator and a squaring, each followed by a serial reduction.
// ----------------------------------------------------------------------------
module modexp_ctrl import modexp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = status_i.mod_small ? ST_DONE : ST_RED_BASE;
        end
      end
      ST_RED_BASE: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_last) begin
          cmd_o.wr_sq = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.exp_zero) begin
          state_d = ST_DONE;
        end else if (status_i.exp_lsb) begin
          state_d = ST_MUL_ACC;
        end else begin
          state_d = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        cmd_o.mul = 1'b1;
        state_d = ST_RED_ACC;
      end
      ST_RED_ACC: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_last) begin
          cmd_o.wr_acc = 1'b1;
          state_d = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        cmd_o.mul    = 1'b1;
        cmd_o.mul_sq = 1'b1;
        state_d = ST_RED_SQ;
      end
      ST_RED_SQ: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_last) begin
          cmd_o.wr_sq     = 1'b1;
          cmd_o.shift_exp = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base_value ** exponent mod modulus by right-to-left
// square-and-multiply on one shared multiplier and serial reducer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the result has been shown. The result appears on power_result_o for exactly
// one cycle with done_o high and cannot be held off, so the receiver must take
// it then. Every modular reduction goes through a restoring divider that
// retires one dividend bit per cycle over R = max(2*MOD_WIDTH, 63) bits: the
// base is reduced first, then for each exponent bit up to its highest set bit
// the square is reduced, after the accumulator product when the bit is set, and
// the result is shown last. A modulus below two answers 0 without a reduction.
// The modulus register is written only while busy and start are both low, so a
// write never lands under an item.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; #(
  parameter int unsigned EXP_WIDTH = 63,
  parameter int unsigned MOD_WIDTH = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [BaseW-1:0]     base_value_i,
  input  logic [EXP_WIDTH-1:0] exponent_i,
  output logic                 done_o,
  output logic [MOD_WIDTH-1:0] power_result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [MOD_WIDTH-1:0] cfg_modulus_i
);

  cmd_t    cmd;
  status_t status;
  logic    ctrl_busy;

  modexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (ctrl_busy),
    .done_o   (done_o)
  );

  modexp_datapath #(
    .EXP_WIDTH (EXP_WIDTH),
    .MOD_WIDTH (MOD_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .acc_o         (power_result_o)
  );

  assign busy        = ctrl_busy;
  assign cfg_ready_o = ~ctrl_busy & ~start;

endmodule

[test/modular_exponentiation_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation regression
// Sends directed and random base/exponent items under several moduli and
// sender idling patterns. Each result is compared against the known value of its
// directed row or a square-and-multiply predictor that runs in the testbench.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;
  import modexp_pkg::*;

  localparam int unsigned ExpW = 63;
  localparam int unsigned ModW = 30;
  localparam logic [BaseW-1:0] BaseMax = '1;
  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam logic [ModW-1:0] ModDefault = ModReset[ModW-1:0];
  localparam logic [ModW-1:0] ModAlt = 30'd1000000007;
  localparam logic [ModW-1:0] ModMax = '1;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [ModW-1:0]  modulus;
    logic [BaseW-1:0] base;
    logic [ExpW-1:0]  exponent;
    bit               known;
    logic [ModW-1:0]  power;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [BaseW-1:0] base_value_i = '0;
  logic [ExpW-1:0] exponent_i = '0;
  logic done_o;
  logic [ModW-1:0] power_result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ModW-1:0] cfg_modulus_i = '0;

  logic [ModW-1:0] expected_powers[$];
  logic [ModW-1:0] modulus_now = ModDefault;
  int unsigned failures = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned wide_items = 0;
  int unsigned modulus_writes = 0;

  // Rows whose result is obvious carry it; the others go to the predictor.
  directed_row_t directed_rows[] = '{
    '{ModDefault, 63'd0, 63'd0, 1'b1, 30'd1},
    '{ModDefault, 63'd7, 63'd0, 1'b1, 30'd1},
    '{ModDefault, BaseMax, 63'd0, 1'b1, 30'd1},
    '{ModDefault, 63'd0, 63'd5, 1'b1, 30'd0},
    '{ModDefault, 63'd1, ExpMax, 1'b1, 30'd1},
    '{ModDefault, 63'd2, 63'd10, 1'b1, 30'd1024},
    '{ModDefault, 63'd3, 63'd1, 1'b1, 30'd3},
    '{ModDefault, 63'd998244353, 63'd1, 1'b1, 30'd0},
    '{ModDefault, 63'd998244352, 63'd2, 1'b1, 30'd1},
    '{ModDefault, 63'd998244352, 63'd1, 1'b1, 30'd998244352},
    '{ModDefault, BaseMax, ExpMax, 1'b0, 30'd0},
    '{ModAlt, 63'd10, 63'd9, 1'b1, 30'd1000000000},
    '{ModAlt, 63'd123456789, 63'd1000000005, 1'b0, 30'd0},
    '{ModMax, BaseMax, 63'd2, 1'b0, 30'd0},
    '{ModMax, 63'd1073741822, 63'd3, 1'b1, 30'd1073741822},
    '{30'd2, 63'd5, 63'd7, 1'b1, 30'd1},
    '{30'd2, 63'd4, 63'd0, 1'b1, 30'd1},
    '{30'd2, 63'd4, 63'd3, 1'b1, 30'd0},
    '{30'd1, 63'd0, 63'd0, 1'b1, 30'd0},
    '{30'd1, BaseMax, ExpMax, 1'b1, 30'd0},
    '{30'd0, 63'd5, 63'd0, 1'b1, 30'd0},
    '{30'd0, BaseMax, 63'd12345, 1'b1, 30'd0}
  };

  modular_exponentiation u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .done_o         (done_o),
    .power_result_o (power_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_modulus_i  (cfg_modulus_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ModW-1:0] modular_power(logic [BaseW-1:0] base,
                                                    logic [ExpW-1:0] exponent,
                                                    logic [ModW-1:0] modulus);
    logic [63:0] m;
    logic [63:0] product;
    logic [63:0] running_square;
    if (modulus < 2) begin
      return '0;
    end
    m = 64'(modulus);
    product = 64'd1;
    running_square = 64'(base) % m;
    for (int i = 0; i < ExpW; i++) begin
      if (exponent[i]) begin
        product = (product * running_square) % m;
      end
      running_square = (running_square * running_square) % m;
    end
    return product[ModW-1:0];
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= MaxReports) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  task automatic send_item(logic [BaseW-1:0] base, logic [ExpW-1:0] exponent,
                           logic [ModW-1:0] power, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    base_value_i <= base;
    exponent_i <= exponent;
    do @(posedge clk_i); while (busy);
    expected_powers = {expected_powers, power};
    items_sent++;
  endtask

  // The modulus may change only once every pending result has come back.
  task automatic write_modulus(logic [ModW-1:0] modulus);
    start <= 1'b0;
    while (expected_powers.size() != 0) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_modulus_i <= modulus;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_now = modulus;
    modulus_writes++;
  endtask

  // Most exponents are short so the run stays fast; a few use all bits.
  function automatic logic [ExpW-1:0] random_exponent();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 3) begin
      return ExpW'(random_word());
    end
    len = (pick < 10) ? $urandom_range(16) : $urandom_range(6);
    return ExpW'(random_word() & ((64'd1 << len) - 64'd1));
  endfunction

  function automatic logic [BaseW-1:0] random_base(logic [ModW-1:0] modulus);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      return BaseW'($urandom_range(3));
    end else if (pick < 4) begin
      return BaseW'(modulus) - BaseW'(1) + BaseW'($urandom_range(2));
    end
    return BaseW'(random_word());
  endfunction

  always @(posedge clk_i) begin
    if (done_o) begin
      results_seen++;
      if (expected_powers.size() == 0) begin
        note_failure($sformatf("result %0d with no item pending", power_result_o));
      end else if (power_result_o !== expected_powers[0]) begin
        note_failure($sformatf("power_result expected %0d, got %0d",
                               expected_powers[0], power_result_o));
        void'(expected_powers.pop_front());
      end else begin
        void'(expected_powers.pop_front());
      end
    end
  end

  initial begin
    logic [ModW-1:0] phase_moduli[6];
    int unsigned idle_pcts[6] = '{0, 49, 0, 31, 49, 31};
    logic [BaseW-1:0] base;
    logic [ExpW-1:0] exponent;

    phase_moduli = '{ModDefault, ModAlt, ModMax, 30'd2,
                     ModW'($urandom_range(32'h3FFF_FFFF, 2)),
                     ModW'($urandom_range(1000, 2))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].modulus != modulus_now) begin
        write_modulus(directed_rows[i].modulus);
      end
      send_item(directed_rows[i].base, directed_rows[i].exponent,
                directed_rows[i].known ? directed_rows[i].power :
                modular_power(directed_rows[i].base, directed_rows[i].exponent,
                              modulus_now), 0);
    end

    for (int p = 0; p < 6; p++) begin
      write_modulus(phase_moduli[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        base = random_base(modulus_now);
        exponent = random_exponent();
        if (exponent > 63'd65535) begin
          wide_items++;
        end
        send_item(base, exponent, modular_power(base, exponent, modulus_now),
                  idle_pcts[p]);
      end
    end
    start <= 1'b0;

    while (expected_powers.size() != 0) begin
      @(posedge clk_i);
    end
    // A stray result would show during the wait below.
    repeat (150) @(posedge clk_i);

    if (expected_powers.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_powers.size()));
    end
    $display("Sent %0d items (%0d with exponents above 16 bits) over %0d modulus writes.",
             items_sent, wide_items, modulus_writes);
    $display("Checked %0d results, %0d failures.", results_seen, failures);
    if (failures == 0) begin
      $display("modular_exponentiation regression: pass");
    end else begin
      $display("modular_exponentiation regression: fail");
    end
    $finish;
  end

  initial begin
    #600000000;
    $display("modular_exponentiation regression: fail");
    $finish;
  end

endmodule
